/* hdl/ptw_pkg.sv */
`default_nettype none

package ptw_pkg;

    localparam int DEF_TABLE_FRAMES  = 16;
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int SLOT_W            = 9;
    localparam int ROOT_W            = 4;
    localparam int FRAME_W           = 40;
    localparam int INDEX_W           = 13;
    localparam int ENTRY_W           = 64;
    localparam int VA_W              = 48;
    localparam int PA_W              = 52;
    localparam int MODE_W            = 2;

    // entry bit positions
    localparam int PTE_PRESENT = 0;
    localparam int PTE_RW      = 1;
    localparam int PTE_PS      = 7;

    // access mode bit for the writable check
    localparam int MODE_WRITE = 1;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_XLATE = 1'b1;

    localparam logic [1:0] LVL_PML4 = 2'd3;
    localparam logic [1:0] LVL_PDPT = 2'd2;
    localparam logic [1:0] LVL_PD   = 2'd1;
    localparam logic [1:0] LVL_PT   = 2'd0;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NOT_PRESENT = 2'd1,
        ST_FRAME_FAULT = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        PG_4K = 2'd0,
        PG_2M = 2'd1,
        PG_1G = 2'd2
    } t_page_size;

    typedef struct packed {
        logic clr_step;
        logic acc_wr;
        logic acc_tr;
        logic walk_step;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
        logic root_bad;
        logic walk_done;
    } t_dp_status;

endpackage

`default_nettype wire

/* hdl/four_level_page_table_walker.sv */
// write item: result registered straight from the accepted item; translate item: one
//   entry-store read per level walked, no walk when the root frame is outside the store
// items do not overlap: the single store read port and the dependent read of each level
//   hold one walk at a time; the next item enters as the result is taken
// reset: synchronous active low; clears root_frame, then sweeps the store to zero,
//   one entry a cycle with input stalled
`default_nettype none

module four_level_page_table_walker #(
    parameter int TABLE_FRAMES = ptw_pkg::DEF_TABLE_FRAMES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [ptw_pkg::ROOT_W-1:0]    i_cfg_wr_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_action,
    input  logic [ptw_pkg::INDEX_W-1:0]   i_entry_index,
    input  logic [ptw_pkg::ENTRY_W-1:0]   i_entry_value,
    input  logic [ptw_pkg::VA_W-1:0]      i_virt_addr,
    input  logic [ptw_pkg::MODE_W-1:0]    i_access_mode,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [ptw_pkg::PA_W-1:0]      o_phys_addr,
    output logic [1:0]                    o_status,
    output logic [1:0]                    o_page_size,
    output logic                          o_access_ok
);

    import ptw_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status dp_status;

    ptw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_action    (i_action),
        .i_stall     (i_stall),
        .i_dp_status (dp_status),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .o_cmd       (cmd)
    );

    ptw_datapath #(
        .TABLE_FRAMES (TABLE_FRAMES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_dp_status   (dp_status),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_entry_index (i_entry_index),
        .i_entry_value (i_entry_value),
        .i_virt_addr   (i_virt_addr),
        .i_access_mode (i_access_mode),
        .o_phys_addr   (o_phys_addr),
        .o_status      (o_status),
        .o_page_size   (o_page_size),
        .o_access_ok   (o_access_ok)
    );

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.clr_step, cmd.acc_wr, cmd.acc_tr, cmd.walk_step}))
        else $error("more than one datapath command at once");

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clr_step |-> o_stall)
        else $error("item accepted during store clear");

    a_write_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_action == ACT_WRITE) |=> (o_valid && o_status == ST_OK))
        else $error("write item gave no ok result");

    a_walk_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.walk_step && dp_status.walk_done) |=> o_valid)
        else $error("finished walk gave no result");

endmodule

`default_nettype wire

/* hdl/ptw_ram.sv */
`default_nettype none

module ptw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* hdl/ptw_ctrl.sv */
`default_nettype none

module ptw_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_action,
    input  logic                i_stall,
    input  ptw_pkg::t_dp_status i_dp_status,
    output logic                o_stall,
    output logic                o_valid,
    output ptw_pkg::t_dp_cmd    o_cmd
);

    import ptw_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_WALK  = 4'b0100,
        S_OUT   = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_valid = (r_state == S_OUT);
    // a new item may enter in the cycle the held result is taken
    assign o_stall = !((r_state == S_IDLE) || ((r_state == S_OUT) && !i_stall));
    assign accept  = i_valid && !o_stall;

    assign o_cmd.clr_step  = (r_state == S_CLEAR);
    assign o_cmd.acc_wr    = accept && (i_action == ACT_WRITE);
    assign o_cmd.acc_tr    = accept && (i_action == ACT_XLATE);
    assign o_cmd.walk_step = (r_state == S_WALK);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_dp_status.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE, S_OUT: begin
                if (accept) begin
                    if (i_action == ACT_WRITE || i_dp_status.root_bad) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_WALK;
                    end
                end else if (r_state == S_OUT && !i_stall) begin
                    n_state = S_IDLE;
                end
            end
            S_WALK: begin
                if (i_dp_status.walk_done) begin
                    n_state = S_OUT;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

/* hdl/ptw_datapath.sv */
`default_nettype none

module ptw_datapath #(
    parameter int TABLE_FRAMES = ptw_pkg::DEF_TABLE_FRAMES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ptw_pkg::t_dp_cmd              i_cmd,
    output ptw_pkg::t_dp_status           o_dp_status,
    input  logic                          i_cfg_wr_en,
    input  logic [ptw_pkg::ROOT_W-1:0]    i_cfg_wr_data,
    input  logic [ptw_pkg::INDEX_W-1:0]   i_entry_index,
    input  logic [ptw_pkg::ENTRY_W-1:0]   i_entry_value,
    input  logic [ptw_pkg::VA_W-1:0]      i_virt_addr,
    input  logic [ptw_pkg::MODE_W-1:0]    i_access_mode,
    output logic [ptw_pkg::PA_W-1:0]      o_phys_addr,
    output logic [1:0]                    o_status,
    output logic [1:0]                    o_page_size,
    output logic                          o_access_ok
);

    import ptw_pkg::*;

    localparam int DEPTH = TABLE_FRAMES * ENTRIES_PER_TABLE;
    localparam int AW    = $clog2(DEPTH);
    localparam int FW    = AW - SLOT_W;
    localparam logic [FRAME_W-1:0] FRAME_LIMIT = FRAME_W'(TABLE_FRAMES);
    localparam logic [AW-1:0]      LAST_ADDR   = AW'(DEPTH - 1);

    function automatic logic [SLOT_W-1:0] va_slot(input logic [VA_W-1:0] va,
                                                   input logic [1:0] lvl);
        logic [SLOT_W-1:0] slot;
        unique case (lvl)
            LVL_PML4: slot = va[47:39];
            LVL_PDPT: slot = va[38:30];
            LVL_PD:   slot = va[29:21];
            LVL_PT:   slot = va[20:12];
            default:  slot = va[20:12];
        endcase
        return slot;
    endfunction

    logic [ROOT_W-1:0]  r_root;
    logic [AW-1:0]      r_clr_addr;
    logic [VA_W-1:0]    r_va;
    logic               r_mode_wr;
    logic [1:0]         r_level;
    logic [PA_W-1:0]    r_phys;
    t_status            r_status;
    t_page_size         r_size;
    logic               r_ok;

    logic               ram_we;
    logic [AW-1:0]      ram_addr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] rdata;

    logic [FRAME_W-1:0] root_ext;
    logic [FRAME_W-1:0] next_frame;
    logic               root_bad;
    logic               next_bad;
    logic               wr_in_range;
    logic               e_present;
    logic               e_large;
    logic               leaf_1g;
    logic               leaf_2m;
    logic               leaf_4k;
    logic               walk_done;
    logic               leaf_ok;
    logic [PA_W-1:0]    walk_phys;
    t_status            walk_status;
    t_page_size         walk_size;
    logic               walk_ok;

    ptw_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (rdata)
    );

    assign root_ext    = FRAME_W'(r_root);
    assign root_bad    = (root_ext >= FRAME_LIMIT);
    assign next_frame  = rdata[51:12];
    assign next_bad    = (next_frame >= FRAME_LIMIT);
    assign wr_in_range = (32'(i_entry_index) < 32'(DEPTH));

    assign e_present = rdata[PTE_PRESENT];
    assign e_large   = rdata[PTE_PS];
    assign leaf_1g   = (r_level == LVL_PDPT) && e_large;
    assign leaf_2m   = (r_level == LVL_PD) && e_large;
    assign leaf_4k   = (r_level == LVL_PT);
    assign walk_done = !e_present || leaf_1g || leaf_2m || leaf_4k || next_bad;
    // present check always passes on a final entry
    assign leaf_ok   = !(r_mode_wr && !rdata[PTE_RW]);

    always_comb begin
        walk_phys   = '0;
        walk_status = ST_OK;
        walk_size   = PG_4K;
        walk_ok     = 1'b0;
        priority if (!e_present) begin
            walk_status = ST_NOT_PRESENT;
        end else if (leaf_1g) begin
            walk_phys = {rdata[51:30], r_va[29:0]};
            walk_size = PG_1G;
            walk_ok   = leaf_ok;
        end else if (leaf_2m) begin
            walk_phys = {rdata[51:21], r_va[20:0]};
            walk_size = PG_2M;
            walk_ok   = leaf_ok;
        end else if (leaf_4k) begin
            walk_phys = {rdata[51:12], r_va[11:0]};
            walk_ok   = leaf_ok;
        end else begin
            walk_status = ST_FRAME_FAULT;
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_wdata = '0;
        priority if (i_cmd.clr_step) begin
            ram_we   = 1'b1;
            ram_addr = r_clr_addr;
        end else if (i_cmd.acc_wr) begin
            ram_we    = wr_in_range;
            ram_addr  = AW'(i_entry_index);
            ram_wdata = i_entry_value;
        end else if (i_cmd.acc_tr) begin
            ram_addr = {FW'(root_ext), i_virt_addr[47:39]};
        end else begin
            // next level read straight from the entry just returned
            ram_addr = {FW'(next_frame), va_slot(r_va, r_level - 2'd1)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root     <= '0;
            r_clr_addr <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_root <= i_cfg_wr_data;
            end
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_wr) begin
            r_phys   <= '0;
            r_status <= ST_OK;
            r_size   <= PG_4K;
            r_ok     <= 1'b0;
        end else if (i_cmd.acc_tr) begin
            r_va      <= i_virt_addr;
            r_mode_wr <= i_access_mode[MODE_WRITE];
            r_level   <= LVL_PML4;
            r_phys    <= '0;
            r_status  <= root_bad ? ST_FRAME_FAULT : ST_OK;
            r_size    <= PG_4K;
            r_ok      <= 1'b0;
        end else if (i_cmd.walk_step) begin
            if (walk_done) begin
                r_phys   <= walk_phys;
                r_status <= walk_status;
                r_size   <= walk_size;
                r_ok     <= walk_ok;
            end else begin
                r_level <= r_level - 2'd1;
            end
        end
    end

    assign o_dp_status.clear_last = (r_clr_addr == LAST_ADDR);
    assign o_dp_status.root_bad   = root_bad;
    assign o_dp_status.walk_done  = walk_done;

    assign o_phys_addr = r_phys;
    assign o_status    = r_status;
    assign o_page_size = r_size;
    assign o_access_ok = r_ok;

endmodule

`default_nettype wire
